/* rtl/core/bfi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared types, constants and saturation helpers for the body integrator.
// ----------------------------------------------------------------------------
package bfi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = 33;  // quotient bits kept by the divider

  localparam logic [30:0] DRAG_K = 31'd107374182;
  localparam logic [30:0] LIFT_K = 31'd42949673;

  localparam logic [2:0] REG_GRAVITY_X   = 3'd0;
  localparam logic [2:0] REG_GRAVITY_Y   = 3'd1;
  localparam logic [2:0] REG_AIR_DENSITY = 3'd2;
  localparam logic [2:0] REG_TIME_STEP   = 3'd3;
  localparam logic [2:0] REG_FORCE_EN    = 3'd4;
  localparam logic [2:0] REG_METHOD      = 3'd5;

  localparam logic [1:0] METH_FWD    = 2'd0;
  localparam logic [1:0] METH_BWD    = 2'd1;
  localparam logic [1:0] METH_VERLET = 2'd2;

  localparam int EN_GRAVITY = 0;
  localparam int EN_DRAG    = 1;
  localparam int EN_LIFT    = 2;

  localparam logic signed [31:0] RST_GRAVITY_X   = 32'sd0;
  localparam logic signed [31:0] RST_GRAVITY_Y   = 32'sd642908;
  localparam logic [30:0]        RST_AIR_DENSITY = 31'd84738;
  localparam logic [30:0]        RST_TIME_STEP   = 31'd1092;
  localparam logic [2:0]         RST_FORCE_EN    = 3'd7;

  typedef struct packed {
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
    logic [30:0]        air_density;
    logic [30:0]        time_step;
    logic [2:0]         force_enables;
    logic [1:0]         integration_method;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        body_mass;
    logic               is_dynamic;
  } body_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic [30:0] satu31(input logic [63:0] x);
    if (x > 64'h7fffffff) return 31'h7fffffff;
    return x[30:0];
  endfunction

endpackage

/* rtl/core/bfi_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_in_if
// Body input channel: valid/ready plus one body record.
// ----------------------------------------------------------------------------
interface bfi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [30:0]        body_mass;
  logic [30:0]        drag_area_x;
  logic [30:0]        drag_area_y;
  logic signed [31:0] push_x;
  logic signed [31:0] push_y;
  logic               is_dynamic;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, body_mass, drag_area_x,
                  drag_area_y, push_x, push_y, is_dynamic, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, body_mass, drag_area_x,
                  drag_area_y, push_x, push_y, is_dynamic, output ready);
  modport mon    (input valid, ready, pos_x, pos_y, vel_x, vel_y, body_mass, drag_area_x,
                  drag_area_y, push_x, push_y, is_dynamic);
endinterface

/* rtl/core/bfi_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_out_if
// Result channel: valid/ready plus updated position and velocity.
// ----------------------------------------------------------------------------
interface bfi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;

  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, output ready);
  modport mon    (input valid, ready, new_pos_x, new_pos_y, new_vel_x, new_vel_y);
endinterface

/* rtl/core/bfi_force.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_force
// Five stage force pipeline: gravity, drag and lift chains, sum and clamp.
// ----------------------------------------------------------------------------
module bfi_force #(
  parameter int FRAC_BITS = bfi_pkg::FRAC_BITS,
  parameter int FW        = 35
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bfi_pkg::cfg_t        cfg,
  bfi_in_if.sink               in_ch,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bfi_pkg::body_t       out_body,
  output logic signed [FW-1:0] out_force [2]
);

  localparam logic signed [FW-1:0] LIM = FW'(400) <<< FRAC_BITS;

  logic [4:0] vld;
  logic [4:0] en;

  bfi_pkg::body_t b1, b2, b3, b4;
  logic signed [31:0] vin [2];
  logic [31:0]        mag [2];
  logic signed [31:0] gin [2];
  logic [30:0]        ain [2];
  logic signed [31:0] pin [2];

  logic [30:0]        ar1 [2], ar2 [2];
  logic signed [31:0] pu1 [2], pu2 [2], pu3 [2], pu4 [2];
  logic [63:0]        sq1 [2];
  logic signed [63:0] gp1 [2];
  logic signed [31:0] gt2 [2], gt3 [2], gt4 [2];
  logic [61:0]        p2 [2], p3 [2], pd4 [2];
  logic [61:0]        pl4;
  logic [30:0]        m3 [2];
  logic               vpos [2];
  logic signed [FW-1:0] td [2], tl, fsum [2];

  always_comb begin
    en[4] = !vld[4] || out_ready;
    for (int k = 3; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end
  assign in_ch.ready = en[0];
  assign out_valid   = vld[4];

  assign vin[0] = in_ch.vel_x;
  assign vin[1] = in_ch.vel_y;
  assign gin[0] = cfg.gravity_x;
  assign gin[1] = cfg.gravity_y;
  assign ain[0] = in_ch.drag_area_x;
  assign ain[1] = in_ch.drag_area_y;
  assign pin[0] = in_ch.push_x;
  assign pin[1] = in_ch.push_y;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i] = vin[i][31] ? (~vin[i] + 32'd1) : vin[i];
      m3[i]  = bfi_pkg::satu31(64'(p3[i] >> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_ch.valid;
      for (int k = 1; k < 5; k++) if (en[k]) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b1 <= '{pos_x: in_ch.pos_x, pos_y: in_ch.pos_y, vel_x: in_ch.vel_x,
              vel_y: in_ch.vel_y, body_mass: in_ch.body_mass,
              is_dynamic: in_ch.is_dynamic};
      for (int i = 0; i < 2; i++) begin
        ar1[i] <= ain[i];
        pu1[i] <= pin[i];
        sq1[i] <= mag[i] * mag[i];
        gp1[i] <= gin[i] * $signed({1'b0, in_ch.body_mass});
      end
    end
    if (en[1]) begin
      b2 <= b1;
      for (int i = 0; i < 2; i++) begin
        ar2[i] <= ar1[i];
        pu2[i] <= pu1[i];
        gt2[i] <= cfg.force_enables[bfi_pkg::EN_GRAVITY] ?
                  bfi_pkg::sat32(gp1[i] >>> FRAC_BITS) : 32'sd0;
        p2[i]  <= bfi_pkg::satu31(sq1[i] >> FRAC_BITS) * cfg.air_density;
      end
    end
    if (en[2]) begin
      b3 <= b2;
      for (int i = 0; i < 2; i++) begin
        pu3[i] <= pu2[i];
        gt3[i] <= gt2[i];
        p3[i]  <= bfi_pkg::satu31(64'(p2[i] >> FRAC_BITS)) * ar2[i];
      end
    end
    if (en[3]) begin
      b4 <= b3;
      for (int i = 0; i < 2; i++) begin
        pu4[i] <= pu3[i];
        gt4[i] <= gt3[i];
        pd4[i] <= m3[i] * bfi_pkg::DRAG_K;
      end
      pl4 <= m3[1] * bfi_pkg::LIFT_K;
    end
    if (en[4]) begin
      out_body <= b4;
      for (int i = 0; i < 2; i++) begin
        if (fsum[i] > LIM) out_force[i] <= LIM;
        else if (fsum[i] < -LIM) out_force[i] <= -LIM;
        else out_force[i] <= fsum[i];
      end
    end
  end

  // drag and lift oppose the velocity
  always_comb begin
    vpos[0] = !b4.vel_x[31] && (b4.vel_x != 32'sd0);
    vpos[1] = !b4.vel_y[31] && (b4.vel_y != 32'sd0);
    tl = FW'($signed({1'b0, pl4[61:32]}));
    if (vpos[1]) tl = -tl;
    if (!cfg.force_enables[bfi_pkg::EN_LIFT]) tl = '0;
    for (int i = 0; i < 2; i++) begin
      td[i] = FW'($signed({1'b0, pd4[i][61:32]}));
      if (vpos[i]) td[i] = -td[i];
      if (!cfg.force_enables[bfi_pkg::EN_DRAG]) td[i] = '0;
      fsum[i] = FW'(pu4[i]) + FW'(gt4[i]) + td[i];
    end
    fsum[1] = fsum[1] + tl;
  end

endmodule

/* rtl/core/bfi_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_div
// Pipelined restoring divider, two lanes: acceleration = (force << FRAC) / mass.
// ----------------------------------------------------------------------------
module bfi_div #(
  parameter int FRAC_BITS = bfi_pkg::FRAC_BITS,
  parameter int FW        = 35
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bfi_pkg::body_t       in_body,
  input  logic signed [FW-1:0] in_force [2],
  output logic                 out_valid,
  input  logic                 out_ready,
  output bfi_pkg::body_t       out_body,
  output logic signed [31:0]   out_accel [2]
);

  localparam int QW = bfi_pkg::QW;
  localparam int NW = FW + FRAC_BITS;
  localparam int DS = QW + 2;

  logic [DS-1:0] vld;
  logic [DS-1:0] en;

  bfi_pkg::body_t bd [QW+1];
  logic [31:0]    rem [QW+1][2];
  logic [QW-1:0]  low [QW+1][2];
  logic [QW-1:0]  quo [QW+1][2];
  logic           sg  [QW+1][2];
  logic           ovf [QW+1][2];
  logic           zro [QW+1];

  logic [FW-1:0]  fabs [2];
  logic [NW-1:0]  num [2];
  logic [31:0]    trial [QW+1][2];
  logic           take [QW+1][2];

  always_comb begin
    en[DS-1] = !vld[DS-1] || out_ready;
    for (int k = DS-2; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end
  assign in_ready  = en[0];
  assign out_valid = vld[DS-1];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      fabs[i] = in_force[i][FW-1] ? FW'(-in_force[i]) : FW'(in_force[i]);
      num[i]  = {fabs[i], {FRAC_BITS{1'b0}}};
    end
    for (int k = 0; k <= QW; k++) begin
      for (int i = 0; i < 2; i++) begin
        trial[k][i] = {rem[k][i][30:0], low[k][i][QW-1]};
        take[k][i]  = trial[k][i] >= {1'b0, bd[k].body_mass};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < DS; k++) if (en[k]) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      bd[0]  <= in_body;
      zro[0] <= in_body.body_mass == 31'd0;
      for (int i = 0; i < 2; i++) begin
        sg[0][i]  <= in_force[i][FW-1];
        ovf[0][i] <= (num[i] >> QW) >= NW'(in_body.body_mass);
        rem[0][i] <= 32'(num[i] >> QW);
        low[0][i] <= num[i][QW-1:0];
        quo[0][i] <= '0;
      end
    end
    for (int k = 1; k <= QW; k++) begin
      if (en[k]) begin
        bd[k]  <= bd[k-1];
        zro[k] <= zro[k-1];
        for (int i = 0; i < 2; i++) begin
          sg[k][i]  <= sg[k-1][i];
          ovf[k][i] <= ovf[k-1][i];
          low[k][i] <= {low[k-1][i][QW-2:0], 1'b0};
          quo[k][i] <= {quo[k-1][i][QW-2:0], take[k-1][i]};
          rem[k][i] <= take[k-1][i] ? (trial[k-1][i] - {1'b0, bd[k-1].body_mass})
                                    : trial[k-1][i];
        end
      end
    end
    if (en[DS-1]) begin
      out_body <= bd[QW];
      for (int i = 0; i < 2; i++) begin
        if (zro[QW]) out_accel[i] <= 32'sd0;
        else if (ovf[QW][i]) out_accel[i] <= sg[QW][i] ? 32'sh80000000 : 32'sh7fffffff;
        else if (!sg[QW][i])
          out_accel[i] <= (quo[QW][i] > QW'(32'h7fffffff)) ? 32'sh7fffffff
                                                          : 32'(quo[QW][i]);
        else
          out_accel[i] <= (quo[QW][i] > QW'(32'h80000000)) ? 32'sh80000000
                                                          : 32'(-quo[QW][i]);
      end
    end
  end

endmodule

/* rtl/core/bfi_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_step
// Four stage integration: dv, new velocity, position update, output register.
// ----------------------------------------------------------------------------
module bfi_step #(
  parameter int FRAC_BITS = bfi_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  bfi_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  bfi_pkg::body_t     in_body,
  input  logic signed [31:0] in_accel [2],
  bfi_out_if.source          out_ch
);

  logic [3:0] vld;
  logic [3:0] en;

  bfi_pkg::body_t b1, b2, b3;
  logic signed [31:0] dts;
  logic signed [31:0] vin [2], pin3 [2], vin3 [2];
  logic signed [63:0] adt1 [2], vdt1 [2], vdt2 [2], vdt3 [2];
  logic signed [63:0] vndt3 [2], dvdt3 [2];
  logic signed [31:0] dvc [2], vnc [2], dv2 [2], vn2 [2], vn3 [2];
  logic signed [31:0] np [2], nv [2];
  logic signed [31:0] np4 [2], nv4 [2];

  assign dts = $signed({1'b0, cfg.time_step});

  always_comb begin
    en[3] = !vld[3] || out_ch.ready;
    for (int k = 2; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end
  assign in_ready     = en[0];
  assign out_ch.valid = vld[3];
  assign out_ch.new_pos_x = np4[0];
  assign out_ch.new_pos_y = np4[1];
  assign out_ch.new_vel_x = nv4[0];
  assign out_ch.new_vel_y = nv4[1];

  assign vin[0]  = in_body.vel_x;
  assign vin[1]  = in_body.vel_y;
  assign pin3[0] = b3.pos_x;
  assign pin3[1] = b3.pos_y;
  assign vin3[0] = b3.vel_x;
  assign vin3[1] = b3.vel_y;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dvc[i] = bfi_pkg::sat32(adt1[i] >>> FRAC_BITS);
      vnc[i] = bfi_pkg::sat32(64'(i == 0 ? b1.vel_x : b1.vel_y) + 64'(dvc[i]));
      np[i]  = pin3[i];
      nv[i]  = vin3[i];
      if (b3.is_dynamic) begin
        unique case (cfg.integration_method)
          bfi_pkg::METH_FWD: begin
            np[i] = bfi_pkg::sat32(64'(pin3[i]) + (vndt3[i] >>> FRAC_BITS));
            nv[i] = vn3[i];
          end
          bfi_pkg::METH_BWD: begin
            np[i] = bfi_pkg::sat32(64'(pin3[i]) + (vdt3[i] >>> FRAC_BITS));
            nv[i] = vn3[i];
          end
          bfi_pkg::METH_VERLET: begin
            np[i] = bfi_pkg::sat32(64'(pin3[i]) + (vdt3[i] >>> FRAC_BITS)
                                   + (dvdt3[i] >>> (FRAC_BITS + 1)));
            nv[i] = vn3[i];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < 4; k++) if (en[k]) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b1 <= in_body;
      for (int i = 0; i < 2; i++) begin
        adt1[i] <= in_accel[i] * dts;
        vdt1[i] <= vin[i] * dts;
      end
    end
    if (en[1]) begin
      b2 <= b1;
      for (int i = 0; i < 2; i++) begin
        dv2[i]  <= dvc[i];
        vn2[i]  <= vnc[i];
        vdt2[i] <= vdt1[i];
      end
    end
    if (en[2]) begin
      b3 <= b2;
      for (int i = 0; i < 2; i++) begin
        vndt3[i] <= vn2[i] * dts;
        dvdt3[i] <= dv2[i] * dts;
        vdt3[i]  <= vdt2[i];
        vn3[i]   <= vn2[i];
      end
    end
    if (en[3]) begin
      for (int i = 0; i < 2; i++) begin
        np4[i] <= np[i];
        nv4[i] <= nv[i];
      end
    end
  end

endmodule

/* rtl/core/body_force_integrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_force_integrator
// Streams bodies through force, divide and integration pipelines.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  body_in    in   valid/ready      position, velocity, mass, areas, push, flag
//  body_out   out  valid/ready      new position, new velocity
//  cfg        in   cfg_we           cfg_index, cfg_data
//
//  One body per cycle sustained while body_out is not stalled; the restoring
//  divider resolves one quotient bit per stage (QW = 33 quotient bits).
//  Every stage holds on its own valid bit; a stage advances when empty or when
//  the next one advances, so a stalled output loses and repeats nothing.
//  Synchronous reset empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
module body_force_integrator #(
  parameter int FRAC_BITS = bfi_pkg::FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  bfi_in_if.sink      body_in,
  bfi_out_if.source   body_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int FW = (FRAC_BITS + 11 > 35) ? FRAC_BITS + 11 : 35;

  bfi_pkg::cfg_t cfg;

  logic               f_valid, f_ready, d_valid, d_ready;
  bfi_pkg::body_t     f_body, d_body;
  logic signed [FW-1:0] f_force [2];
  logic signed [31:0] d_accel [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity_x          <= bfi_pkg::RST_GRAVITY_X;
      cfg.gravity_y          <= bfi_pkg::RST_GRAVITY_Y;
      cfg.air_density        <= bfi_pkg::RST_AIR_DENSITY;
      cfg.time_step          <= bfi_pkg::RST_TIME_STEP;
      cfg.force_enables      <= bfi_pkg::RST_FORCE_EN;
      cfg.integration_method <= bfi_pkg::METH_FWD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfi_pkg::REG_GRAVITY_X:   cfg.gravity_x          <= cfg_data;
        bfi_pkg::REG_GRAVITY_Y:   cfg.gravity_y          <= cfg_data;
        bfi_pkg::REG_AIR_DENSITY: cfg.air_density        <= cfg_data[30:0];
        bfi_pkg::REG_TIME_STEP:   cfg.time_step          <= cfg_data[30:0];
        bfi_pkg::REG_FORCE_EN:    cfg.force_enables      <= cfg_data[2:0];
        bfi_pkg::REG_METHOD:      cfg.integration_method <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  bfi_force #(.FRAC_BITS(FRAC_BITS), .FW(FW)) u_force (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (body_in),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_body  (f_body),
    .out_force (f_force)
  );

  bfi_div #(.FRAC_BITS(FRAC_BITS), .FW(FW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_body   (f_body),
    .in_force  (f_force),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_body  (d_body),
    .out_accel (d_accel)
  );

  bfi_step #(.FRAC_BITS(FRAC_BITS)) u_step (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .in_body  (d_body),
    .in_accel (d_accel),
    .out_ch   (body_out)
  );

endmodule

/* rtl/core/bfi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_checker
// Port-level checks on the body integrator, bound to the top level.
// ----------------------------------------------------------------------------
module bfi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] new_pos_x,
  input logic [31:0] new_pos_y,
  input logic [31:0] new_vel_x,
  input logic [31:0] new_vel_y
);

  // reset empties every stage
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

  // input back-pressure only when the whole pipe is full behind a stalled result
  a_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid
      && $stable(new_pos_x) && $stable(new_pos_y)
      && $stable(new_vel_x) && $stable(new_vel_y))
    else $error("stalled result changed");

endmodule

bind body_force_integrator bfi_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (body_in.valid),
  .in_ready  (body_in.ready),
  .out_valid (body_out.valid),
  .out_ready (body_out.ready),
  .new_pos_x (body_out.new_pos_x),
  .new_pos_y (body_out.new_pos_y),
  .new_vel_x (body_out.new_vel_x),
  .new_vel_y (body_out.new_vel_y)
);

/* bench/tb_body_force_integrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_body_force_integrator
// Streams bodies through the integrator under several register settings and
// flow-control patterns. A scoreboard predicts each updated position and
// velocity from the accepted body and compares every result in order.
// ----------------------------------------------------------------------------
module tb_body_force_integrator;

  localparam logic [1:0] METH_HOLD = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int BODY_COUNT = 950;
  localparam int PER_SETTING = (BODY_COUNT - 58) / 12;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        body_mass;
    logic [30:0]        drag_area_x;
    logic [30:0]        drag_area_y;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic               is_dynamic;
  } body_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } body_state_t;

  class body_scoreboard;
    bfi_pkg::cfg_t cfg;
    body_state_t   pending[$];
    int            mismatches;
    int            checked;

    function longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function logic [63:0] clip31(logic [63:0] x);
      return (x > 64'h7fffffff) ? 64'h7fffffff : x;
    endfunction

    function longint resist(longint v, logic [63:0] area, logic [63:0] k);
      logic [63:0] m;
      m = (v < 0) ? -v : v;
      m = clip31((m * m) >> bfi_pkg::FRAC_BITS);
      m = clip31((m * {33'd0, cfg.air_density}) >> bfi_pkg::FRAC_BITS);
      m = clip31((m * area) >> bfi_pkg::FRAC_BITS);
      m = (m * k) >> 32;
      return (v > 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint accel_of(longint f, logic [63:0] mass);
      logic [63:0] q;
      if (mass == 0) return 0;
      q = ((f < 0 ? -f : f) << bfi_pkg::FRAC_BITS) / mass;
      return sat(f < 0 ? -longint'(q) : longint'(q));
    endfunction

    function void step_axis(longint p, longint v, longint a,
                            output logic signed [31:0] np,
                            output logic signed [31:0] nv);
      longint dt, dv, vn;
      dt = longint'(cfg.time_step);
      dv = sat((a * dt) >>> bfi_pkg::FRAC_BITS);
      vn = sat(v + dv);
      case (cfg.integration_method)
        bfi_pkg::METH_FWD: begin
          np = 32'(sat(p + ((vn * dt) >>> bfi_pkg::FRAC_BITS)));
          nv = 32'(vn);
        end
        bfi_pkg::METH_BWD: begin
          np = 32'(sat(p + ((v * dt) >>> bfi_pkg::FRAC_BITS)));
          nv = 32'(vn);
        end
        bfi_pkg::METH_VERLET: begin
          np = 32'(sat(p + ((v * dt) >>> bfi_pkg::FRAC_BITS)
                       + ((dv * dt) >>> (bfi_pkg::FRAC_BITS + 1))));
          nv = 32'(vn);
        end
        default: begin
          np = 32'(p);
          nv = 32'(v);
        end
      endcase
    endfunction

    function body_state_t integrate(body_item_t b);
      body_state_t r;
      longint fx, fy, lim, mass;
      r = '{b.pos_x, b.pos_y, b.vel_x, b.vel_y};
      if (!b.is_dynamic) return r;
      lim = longint'(400) << bfi_pkg::FRAC_BITS;
      mass = longint'(b.body_mass);
      fx = b.push_x;
      fy = b.push_y;
      if (cfg.force_enables[bfi_pkg::EN_GRAVITY]) begin
        fx += sat((longint'(cfg.gravity_x) * mass) >>> bfi_pkg::FRAC_BITS);
        fy += sat((longint'(cfg.gravity_y) * mass) >>> bfi_pkg::FRAC_BITS);
      end
      if (cfg.force_enables[bfi_pkg::EN_DRAG]) begin
        fx += resist(b.vel_x, {33'd0, b.drag_area_x}, {33'd0, bfi_pkg::DRAG_K});
        fy += resist(b.vel_y, {33'd0, b.drag_area_y}, {33'd0, bfi_pkg::DRAG_K});
      end
      if (cfg.force_enables[bfi_pkg::EN_LIFT])
        fy += resist(b.vel_y, {33'd0, b.drag_area_y}, {33'd0, bfi_pkg::LIFT_K});
      if (fx > lim) fx = lim;
      if (fx < -lim) fx = -lim;
      if (fy > lim) fy = lim;
      if (fy < -lim) fy = -lim;
      step_axis(b.pos_x, b.vel_x, accel_of(fx, mass), r.new_pos_x, r.new_vel_x);
      step_axis(b.pos_y, b.vel_y, accel_of(fy, mass), r.new_pos_y, r.new_vel_y);
      return r;
    endfunction

    function void note_body(body_item_t b);
      pending.push_back(integrate(b));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s at result %0d: got %h want %h", what, checked, got, want);
      mismatches++;
    endtask

    task check_result(body_state_t got);
      body_state_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.new_pos_x, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.new_pos_x !== want.new_pos_x) report("new_pos_x", got.new_pos_x, want.new_pos_x);
      if (got.new_pos_y !== want.new_pos_y) report("new_pos_y", got.new_pos_y, want.new_pos_y);
      if (got.new_vel_x !== want.new_vel_x) report("new_vel_x", got.new_vel_x, want.new_vel_x);
      if (got.new_vel_y !== want.new_vel_y) report("new_vel_y", got.new_vel_y, want.new_vel_y);
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  bfi_in_if  body_in ();
  bfi_out_if body_out ();

  body_force_integrator dut (
    .clk       (clk),
    .rst       (rst),
    .body_in   (body_in),
    .body_out  (body_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  body_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;
  int sent;
  int settings_run;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && body_in.valid && body_in.ready)
      sb.note_body('{body_in.pos_x, body_in.pos_y, body_in.vel_x, body_in.vel_y,
                     body_in.body_mass, body_in.drag_area_x, body_in.drag_area_y,
                     body_in.push_x, body_in.push_y, body_in.is_dynamic});
    if (!rst && body_out.valid && body_out.ready)
      sb.check_result('{body_out.new_pos_x, body_out.new_pos_y,
                        body_out.new_vel_x, body_out.new_vel_y});
    body_out.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((body_in.valid && body_in.ready) || (body_out.valid && body_out.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return $urandom_range(255) - 128;
      default: return ($urandom_range(1) ? 32'd1 : -32'd1) * $urandom_range(32'h00ffffff);
    endcase
  endfunction

  function automatic body_item_t pick_body();
    body_item_t b;
    if ($urandom_range(9) < 7) begin
      b.pos_x = $urandom_range(32'h0fffffff) - 32'h08000000;
      b.pos_y = $urandom_range(32'h0fffffff) - 32'h08000000;
      b.vel_x = $urandom_range(32'h007fffff) - 32'h003fffff;
      b.vel_y = $urandom_range(32'h007fffff) - 32'h003fffff;
      b.body_mass = 31'($urandom_range(32'h00640000, 32'h00001000));
      b.drag_area_x = 31'($urandom_range(32'h00040000));
      b.drag_area_y = 31'($urandom_range(32'h00040000));
      b.push_x = $urandom_range(32'h03ffffff) - 32'h01ffffff;
      b.push_y = $urandom_range(32'h03ffffff) - 32'h01ffffff;
      b.is_dynamic = ($urandom_range(9) != 0);
    end else begin
      b.pos_x = pick_word();
      b.pos_y = pick_word();
      b.vel_x = pick_word();
      b.vel_y = pick_word();
      b.body_mass = 31'(pick_word());
      b.drag_area_x = 31'(pick_word());
      b.drag_area_y = 31'(pick_word());
      b.push_x = pick_word();
      b.push_y = pick_word();
      b.is_dynamic = 1'($urandom_range(1));
    end
    return b;
  endfunction

  task send_body(body_item_t b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      body_in.valid <= 1'b0;
      @(posedge clk);
    end
    body_in.valid       <= 1'b1;
    body_in.pos_x       <= b.pos_x;
    body_in.pos_y       <= b.pos_y;
    body_in.vel_x       <= b.vel_x;
    body_in.vel_y       <= b.vel_y;
    body_in.body_mass   <= b.body_mass;
    body_in.drag_area_x <= b.drag_area_x;
    body_in.drag_area_y <= b.drag_area_y;
    body_in.push_x      <= b.push_x;
    body_in.push_y      <= b.push_y;
    body_in.is_dynamic  <= b.is_dynamic;
    do @(posedge clk); while (!body_in.ready);
    sent++;
  endtask

  task drain();
    body_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // write enable stays high across a burst; the caller drops it afterwards
  task write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      bfi_pkg::REG_GRAVITY_X:   sb.cfg.gravity_x = value;
      bfi_pkg::REG_GRAVITY_Y:   sb.cfg.gravity_y = value;
      bfi_pkg::REG_AIR_DENSITY: sb.cfg.air_density = value[30:0];
      bfi_pkg::REG_TIME_STEP:   sb.cfg.time_step = value[30:0];
      bfi_pkg::REG_FORCE_EN:    sb.cfg.force_enables = value[2:0];
      bfi_pkg::REG_METHOD:      sb.cfg.integration_method = value[1:0];
      default: ;
    endcase
  endtask

  task apply_setting(int k);
    logic [31:0] gx, gy, dens, dt;
    gx   = (k % 3 == 0) ? 32'h7fffffff : (k % 3 == 1) ? 32'h80000000 : pick_word();
    gy   = (k % 4 == 0) ? 32'h80000000 : pick_word();
    dens = (k % 5 == 0) ? 32'h7fffffff : (k % 5 == 1) ? 32'd0 : $urandom_range(32'h00200000);
    dt   = (k % 6 == 0) ? 32'h7fffffff : (k % 6 == 1) ? 32'd0 : $urandom_range(32'h00010000);
    write_reg(bfi_pkg::REG_GRAVITY_X, gx);
    write_reg(bfi_pkg::REG_GRAVITY_Y, gy);
    write_reg(bfi_pkg::REG_AIR_DENSITY, dens);
    write_reg(bfi_pkg::REG_TIME_STEP, dt);
    write_reg(bfi_pkg::REG_FORCE_EN, 32'(k % 8));
    write_reg(bfi_pkg::REG_METHOD,
              32'((k % 4 == 0) ? bfi_pkg::METH_FWD : (k % 4 == 1) ? bfi_pkg::METH_BWD :
                  (k % 4 == 2) ? bfi_pkg::METH_VERLET : METH_HOLD));
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin
    body_item_t b;
    sb = new();
    sb.cfg = '{bfi_pkg::RST_GRAVITY_X, bfi_pkg::RST_GRAVITY_Y, bfi_pkg::RST_AIR_DENSITY,
               bfi_pkg::RST_TIME_STEP, bfi_pkg::RST_FORCE_EN, bfi_pkg::METH_FWD};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    sent = 0;
    settings_run = 1;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = bfi_pkg::REG_GRAVITY_X;
    cfg_data = '0;
    body_in.valid = 1'b0;
    body_in.pos_x = '0;
    body_in.pos_y = '0;
    body_in.vel_x = '0;
    body_in.vel_y = '0;
    body_in.body_mass = '0;
    body_in.drag_area_x = '0;
    body_in.drag_area_y = '0;
    body_in.push_x = '0;
    body_in.push_y = '0;
    body_in.is_dynamic = 1'b0;
    body_out.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed bodies under reset defaults
    send_body('{32'sd100, -32'sd100, 32'sd65536, -32'sd65536, 31'd65536,
                31'd65536, 31'd65536, 32'sd0, 32'sd0, 1'b0});
    send_body('{32'sd5, 32'sd6, 32'sd7, 32'sd8, 31'd0, 31'd1, 31'd1,
                32'sd1000, -32'sd1000, 1'b1});
    send_body('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 32'sh7fffffff,
                32'sh80000000, 1'b1});
    send_body('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                31'd1, 31'h7fffffff, 31'h7fffffff, 32'sh80000000,
                32'sh7fffffff, 1'b1});
    send_body('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd1, 31'd0, 31'd0,
                32'sd0, 32'sd0, 1'b1});
    send_body('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'h7fffffff, 31'd0, 31'd0,
                32'sd0, 32'sd0, 1'b1});
    send_body('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                31'h7fffffff, 31'd0, 31'd0, 32'sh7fffffff, 32'sh7fffffff, 1'b0});
    send_body('{32'sd0, 32'sd0, 32'sh01000000, -32'sh01000000, 31'd65536,
                31'h00100000, 31'h00100000, 32'sd0, 32'sd0, 1'b1});
    send_body('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd1, 31'd0, 31'd0,
                32'sd26214400, -32'sd26214400, 1'b1});
    send_body('{-32'sd1, -32'sd1, -32'sd1, -32'sd1, 31'd1, 31'd1, 31'd1,
                -32'sd1, -32'sd1, 1'b1});
    for (int i = 0; i < 8; i++) send_body(pick_body());
    drain();

    for (int k = 0; k < 12; k++) begin
      apply_setting(k);
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int i = 0; i < PER_SETTING; i++) begin
        b = pick_body();
        send_body(b);
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(bfi_pkg::REG_GRAVITY_X, bfi_pkg::RST_GRAVITY_X);
    write_reg(bfi_pkg::REG_GRAVITY_Y, bfi_pkg::RST_GRAVITY_Y);
    write_reg(bfi_pkg::REG_AIR_DENSITY, 32'(bfi_pkg::RST_AIR_DENSITY));
    write_reg(bfi_pkg::REG_TIME_STEP, 32'(bfi_pkg::RST_TIME_STEP));
    write_reg(bfi_pkg::REG_FORCE_EN, 32'(bfi_pkg::RST_FORCE_EN));
    write_reg(bfi_pkg::REG_METHOD, 32'(bfi_pkg::METH_VERLET));
    cfg_we <= 1'b0;
    for (int i = 0; i < 40; i++) send_body(pick_body());
    drain();

    $display("covered %0d bodies over %0d register settings, %0d results checked",
             sent, settings_run + 1, sb.checked);
    $display("flow control: free run, sparse sender, stalling receiver, light both");
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/bfi_pkg.sv
rtl/core/bfi_in_if.sv
rtl/core/bfi_out_if.sv
rtl/core/bfi_force.sv
rtl/core/bfi_div.sv
rtl/core/bfi_step.sv
rtl/core/body_force_integrator.sv
rtl/core/bfi_checker.sv
bench/tb_body_force_integrator.sv
